/* rtl/pbm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pbm_pkg
// shared types and constants of the pixel blend mode unit
// ----------------------------------------------------------------------------
package pbm_pkg;

    localparam int unsigned PIX_W = 8;   // channel code width
    localparam int unsigned N_W   = 9;   // search range of the rounded code, 0..511
    localparam int unsigned P_W   = 37;  // numerator width
    localparam int unsigned D_W   = 24;  // denominator width
    localparam int unsigned KM_W  = 34;  // (2k)^2 * m width
    localparam int unsigned ACC_W = 40;  // compare accumulator width
    localparam int unsigned MAG_W = 19;  // magnitude width used in root compares
    localparam int unsigned CELLS = N_W + 1;

    typedef enum logic [3:0] {
        MODE_MULTIPLY = 4'd0,
        MODE_SCREEN   = 4'd1,
        MODE_OVERLAY  = 4'd2,
        MODE_HARD     = 4'd3,
        MODE_SOFT_PS  = 4'd4,
        MODE_PEGTOP   = 4'd5,
        MODE_W3C      = 4'd6,
        MODE_CDODGE   = 4'd7,
        MODE_ADD      = 4'd8,
        MODE_CBURN    = 4'd9,
        MODE_SUB      = 4'd10,
        MODE_DIVIDE   = 4'd11,
        MODE_DIFF     = 4'd12,
        MODE_DARKEN   = 4'd13,
        MODE_LIGHTEN  = 4'd14,
        MODE_AVERAGE  = 4'd15
    } t_mode;

    // value to round is (p + k*sqrt(m)) / d, held as compare terms
    typedef struct packed {
        logic signed [ACC_W-1:0] acc;    // 2*n*d - d - 2*p for the code found so far
        logic [D_W-1:0]          d;
        logic [KM_W-1:0]         kk2m;   // (2k)^2 * m
        logic                    sqrtf;  // root term present
        logic                    kneg;   // root term subtracts
        logic                    forced; // result fixed by a zero divisor
        logic [PIX_W-1:0]        fval;
        logic                    fclip;
    } t_work;

    typedef struct packed {
        t_work          w;
        logic [N_W-1:0] r;    // code bits settled so far
        logic           ok0;  // value reaches at least -1/2
    } t_cell;

endpackage
`default_nettype wire

/* rtl/pbm_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pbm_in_if
// operand channel: top and bottom channel codes
// ----------------------------------------------------------------------------
interface pbm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] top_value;
    logic [7:0] bottom_value;

    modport source (output valid, output top_value, output bottom_value, input ready);
    modport sink   (input valid, input top_value, input bottom_value, output ready);
endinterface
`default_nettype wire

/* rtl/pbm_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pbm_out_if
// result channel: blended code and clip flag
// ----------------------------------------------------------------------------
interface pbm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] blended_value;
    logic       clipped;

    modport source (output valid, output blended_value, output clipped, input ready);
    modport sink   (input valid, input blended_value, input clipped, output ready);
endinterface
`default_nettype wire

/* rtl/pbm_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pbm_front
// operand pipeline: forms numerator, denominator and root terms per mode
// ----------------------------------------------------------------------------
module pbm_front
    import pbm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_mode            i_mode,
    input  wire logic             i_valid,
    input  wire logic [PIX_W-1:0] i_a,
    input  wire logic [PIX_W-1:0] i_b,
    output logic                  o_ready,
    output logic                  o_valid,
    output t_work                 o_work,
    input  wire logic             i_ready
);

    typedef struct packed {
        logic [7:0]         a;
        logic [7:0]         b;
        t_mode              mode;
        logic signed [9:0]  k;
        logic [15:0]        ab;
        logic [15:0]        aa;
        logic [15:0]        iaib;
        logic [15:0]        aia;
        logic [15:0]        aib;
        logic [16:0]        k2;
        logic signed [18:0] ka;
    } t_s1;

    typedef struct packed {
        logic [7:0]         a;
        logic [7:0]         b;
        t_mode              mode;
        logic signed [9:0]  k;
        logic [15:0]        ab;
        logic [15:0]        aa;
        logic [15:0]        iaib;
        logic [15:0]        aib;
        logic signed [18:0] ka;
        logic [23:0]        a3;
        logic signed [26:0] kaa;
        logic signed [26:0] kaia;
        logic [KM_W-1:0]    kk2m;
    } t_s2;

    typedef struct packed {
        logic [7:0]           a;
        logic signed [9:0]    k;
        logic signed [25:0]   x;
        logic                 mid6;
        logic signed [P_W-1:0] p;
        logic [D_W-1:0]       d;
        logic [KM_W-1:0]      kk2m;
        logic                 sqrtf;
        logic                 kneg;
        logic                 forced;
        logic [PIX_W-1:0]     fval;
        logic                 fclip;
    } t_s3;

    t_s1 r_s1, n_s1;
    t_s2 r_s2, n_s2;
    t_s3 r_s3, n_s3, r_s4, n_s4;
    t_work r_s5, n_s5;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;

    assign w_rdy5  = !r_v5 || i_ready;
    assign w_rdy4  = !r_v4 || w_rdy5;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v5;
    assign o_work  = r_s5;

    // stage 1: first-level products
    always_comb begin
        logic [7:0]         ia;
        logic [7:0]         ib;
        logic signed [19:0] k2w;
        ia = 8'd255 - i_a;
        ib = 8'd255 - i_b;
        n_s1.a    = i_a;
        n_s1.b    = i_b;
        n_s1.mode = i_mode;
        n_s1.k    = $signed({1'b0, i_b, 1'b0}) - 10'sd255;
        n_s1.ab   = i_a * i_b;
        n_s1.aa   = i_a * i_a;
        n_s1.iaib = ia * ib;
        n_s1.aia  = i_a * ia;
        n_s1.aib  = i_a * ib;
        k2w       = n_s1.k * n_s1.k;
        n_s1.k2   = k2w[16:0];
        n_s1.ka   = n_s1.k * $signed({1'b0, i_a});
    end

    // stage 2: second-level products
    always_comb begin
        logic [15:0] a255;
        logic [31:0] km;
        a255 = {r_s1.a, 8'd0} - 16'(r_s1.a);
        km   = 32'(r_s1.k2) * 32'(a255);
        n_s2.a    = r_s1.a;
        n_s2.b    = r_s1.b;
        n_s2.mode = r_s1.mode;
        n_s2.k    = r_s1.k;
        n_s2.ab   = r_s1.ab;
        n_s2.aa   = r_s1.aa;
        n_s2.iaib = r_s1.iaib;
        n_s2.aib  = r_s1.aib;
        n_s2.ka   = r_s1.ka;
        n_s2.a3   = 24'(r_s1.aa) * 24'(r_s1.a);
        n_s2.kaa  = r_s1.k * $signed({1'b0, r_s1.aa});
        n_s2.kaia = r_s1.k * $signed({1'b0, r_s1.aia});
        n_s2.kk2m = {km, 2'b00};
    end

    // stage 3: per-mode numerator and denominator
    always_comb begin
        logic signed [33:0] xw;
        logic [P_W-1:0]     pa;
        logic [P_W-1:0]     pb;
        pa = P_W'(r_s2.a);
        pb = P_W'(r_s2.b);
        xw = 34'sd16 * $signed({10'd0, r_s2.a3})
           - 34'sd3060 * $signed({18'd0, r_s2.aa})
           + 34'sd195075 * $signed({26'd0, r_s2.a});
        n_s3.a      = r_s2.a;
        n_s3.k      = r_s2.k;
        n_s3.x      = xw[25:0];
        n_s3.mid6   = 1'b0;
        n_s3.p      = '0;
        n_s3.d      = D_W'(255);
        n_s3.kk2m   = '0;
        n_s3.sqrtf  = 1'b0;
        n_s3.kneg   = 1'b0;
        n_s3.forced = 1'b0;
        n_s3.fval   = '0;
        n_s3.fclip  = 1'b0;
        unique case (r_s2.mode)
            MODE_MULTIPLY: n_s3.p = P_W'(r_s2.ab);
            MODE_SCREEN:   n_s3.p = P_W'(65025) - P_W'(r_s2.iaib);
            MODE_OVERLAY: begin
                if (r_s2.a <= 8'd127) n_s3.p = P_W'(r_s2.ab) << 1;
                else n_s3.p = P_W'(65025) - (P_W'(r_s2.iaib) << 1);
            end
            MODE_HARD: begin
                if (r_s2.b <= 8'd127) n_s3.p = P_W'(r_s2.ab) << 1;
                else n_s3.p = P_W'(65025) - (P_W'(r_s2.iaib) << 1);
            end
            MODE_SOFT_PS: begin
                if (r_s2.b <= 8'd127) begin
                    n_s3.p = P_W'(r_s2.ab) * P_W'(510) - P_W'(r_s2.kaa);
                    n_s3.d = D_W'(65025);
                end else begin
                    n_s3.p     = P_W'(r_s2.aib) << 1;
                    n_s3.kk2m  = r_s2.kk2m;
                    n_s3.sqrtf = 1'b1;
                    n_s3.kneg  = r_s2.k[9];
                end
            end
            MODE_PEGTOP: begin
                n_s3.p = P_W'(r_s2.ab) * P_W'(510) - P_W'(r_s2.kaa);
                n_s3.d = D_W'(65025);
            end
            MODE_W3C: begin
                if (r_s2.b <= 8'd127) begin
                    n_s3.p = pa * P_W'(65025) + P_W'(r_s2.kaia);
                    n_s3.d = D_W'(65025);
                end else if (r_s2.a <= 8'd63) begin
                    n_s3.mid6 = 1'b1;
                    n_s3.d    = D_W'(16581375);
                end else begin
                    n_s3.p     = pa * P_W'(255) - P_W'(r_s2.ka);
                    n_s3.kk2m  = r_s2.kk2m;
                    n_s3.sqrtf = 1'b1;
                    n_s3.kneg  = r_s2.k[9];
                end
            end
            MODE_CDODGE: begin
                n_s3.p = pb * P_W'(255);
                n_s3.d = D_W'(8'd255 - r_s2.a);
                if (r_s2.a == 8'd255) begin
                    n_s3.forced = 1'b1;
                    n_s3.fval   = 8'd255;
                    n_s3.fclip  = 1'b1;
                end
            end
            MODE_ADD: begin
                n_s3.p = pa + pb;
                n_s3.d = D_W'(1);
            end
            MODE_CBURN: begin
                n_s3.p = (pa + pb - P_W'(255)) * P_W'(255);
                n_s3.d = D_W'(r_s2.a);
                if (r_s2.a == 8'd0) begin
                    n_s3.forced = 1'b1;
                    n_s3.fclip  = 1'b1;
                end
            end
            MODE_SUB: begin
                n_s3.p = pa + pb - P_W'(255);
                n_s3.d = D_W'(1);
            end
            MODE_DIVIDE: begin
                n_s3.p = pa * P_W'(255);
                n_s3.d = D_W'(r_s2.b);
                if (r_s2.b == 8'd0) begin
                    n_s3.forced = 1'b1;
                    n_s3.fval   = 8'd255;
                    n_s3.fclip  = 1'b1;
                end
            end
            MODE_DIFF: begin
                n_s3.p = (r_s2.a > r_s2.b) ? pa - pb : pb - pa;
                n_s3.d = D_W'(1);
            end
            MODE_DARKEN: begin
                n_s3.p = (r_s2.a < r_s2.b) ? pa : pb;
                n_s3.d = D_W'(1);
            end
            MODE_LIGHTEN: begin
                n_s3.p = (r_s2.a < r_s2.b) ? pb : pa;
                n_s3.d = D_W'(1);
            end
            MODE_AVERAGE: begin
                n_s3.p = pa + pb;
                n_s3.d = D_W'(2);
            end
            default: n_s3.p = '0;
        endcase
    end

    // stage 4: cubic branch of w3c soft light
    always_comb begin
        logic signed [35:0] kx;
        kx   = r_s3.k * r_s3.x;
        n_s4 = r_s3;
        if (r_s3.mid6) begin
            n_s4.p = P_W'(r_s3.a) * P_W'(16581375) + P_W'(kx);
        end
    end

    // stage 5: compare accumulator for code zero
    always_comb begin
        n_s5.acc    = -ACC_W'(r_s4.d) - (ACC_W'(r_s4.p) <<< 1);
        n_s5.d      = r_s4.d;
        n_s5.kk2m   = r_s4.kk2m;
        n_s5.sqrtf  = r_s4.sqrtf;
        n_s5.kneg   = r_s4.kneg;
        n_s5.forced = r_s4.forced;
        n_s5.fval   = r_s4.fval;
        n_s5.fclip  = r_s4.fclip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
            if (w_rdy5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) r_s1 <= n_s1;
        if (w_rdy2) r_s2 <= n_s2;
        if (w_rdy3) r_s3 <= n_s3;
        if (w_rdy4) r_s4 <= n_s4;
        if (w_rdy5) r_s5 <= n_s5;
    end

endmodule
`default_nettype wire

/* rtl/pbm_round_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pbm_round_cell
// one step of the rounded-code search: tries one code bit, keeps it if the
// trial code minus one half still lies at or below the value
// ----------------------------------------------------------------------------
module pbm_round_cell
    import pbm_pkg::*;
#(
    parameter int BIT_IDX = 0  // code bit decided here, -1 checks code zero
)
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_cell i_cell,
    output logic       o_ready,
    output logic       o_valid,
    output t_cell      o_cell,
    input  wire logic  i_ready
);

    localparam int SH   = (BIT_IDX < 0) ? 0 : BIT_IDX + 1;
    localparam int SQ_W = 2 * MAG_W;

    logic                    r_valid;
    t_cell                   r_cell, n_cell;
    logic signed [ACC_W-1:0] w_trial;
    logic [ACC_W-1:0]        w_mag;
    logic [SQ_W-1:0]         w_sq;
    logic                    w_nonpos;
    logic                    w_pred;
    logic                    w_rdy;

    always_comb begin
        if (BIT_IDX < 0) w_trial = i_cell.w.acc;
        else w_trial = i_cell.w.acc + (ACC_W'(i_cell.w.d) << SH);
        w_mag    = w_trial[ACC_W-1] ? ACC_W'(-w_trial) : ACC_W'(w_trial);
        w_sq     = SQ_W'(w_mag[MAG_W-1:0]) * SQ_W'(w_mag[MAG_W-1:0]);
        w_nonpos = w_trial[ACC_W-1] || (w_trial == '0);
        // root term: compare squares, sign of the root coefficient picks the sense
        if (!i_cell.w.sqrtf) w_pred = w_nonpos;
        else if (i_cell.w.kneg) w_pred = w_trial[ACC_W-1] && (w_sq >= SQ_W'(i_cell.w.kk2m));
        else w_pred = w_nonpos || (w_sq <= SQ_W'(i_cell.w.kk2m));
    end

    generate
        if (BIT_IDX < 0) begin : g_zero
            always_comb begin
                n_cell     = i_cell;
                n_cell.ok0 = w_pred;
            end
        end else begin : g_bit
            always_comb begin
                n_cell = i_cell;
                if (w_pred) begin
                    n_cell.w.acc    = w_trial;
                    n_cell.r[BIT_IDX] = 1'b1;
                end
            end
        end
    endgenerate

    assign w_rdy   = !r_valid || i_ready;
    assign o_ready = w_rdy;
    assign o_valid = r_valid;
    assign o_cell  = r_cell;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_rdy) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy) r_cell <= n_cell;
    end

endmodule
`default_nettype wire

/* rtl/pixel_blend_mode_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_blend_mode_unit
// per-channel layer blend of a top and a bottom 8-bit code under one of
// sixteen modes, rounded to nearest and clamped, with a clip flag
// ----------------------------------------------------------------------------
// usage
//  - i_pix carries top_value and bottom_value; a transaction completes when
//    valid and ready are both high at a rising edge of i_clk
//  - o_px returns blended_value and clipped, one transaction per input, in order
//  - i_cfg_we / i_cfg_data write the 4-bit blend mode; write it only while
//    no transaction is in flight
//  - an input transaction reaches the output through five operand stages,
//    ten search cells (code zero and nine code bits) and the output
//    register
//  - throughput is one transaction per cycle; every stage holds its own
//    valid bit, so the block keeps accepting while bubbles remain even when
//    the receiver stalls, and stops only once every stage is full
//  - reset (synchronous, active low) empties the pipeline and sets the mode
//    to multiply
//  - a stalled result stays on o_px until it is taken
// ----------------------------------------------------------------------------
module pixel_blend_mode_unit
    import pbm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [3:0] i_cfg_data,
    pbm_in_if.sink          i_pix,
    pbm_out_if.source       o_px
);

    // blend mode register
    t_mode r_mode, n_mode;

    assign n_mode = i_cfg_we ? t_mode'(i_cfg_data) : r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_MULTIPLY;
        end else begin
            r_mode <= n_mode;
        end
    end

    // operand pipeline
    logic  w_front_valid;
    t_work w_front_work;

    // search chain, element 0 is fed by the operand pipeline
    logic  w_valid [CELLS+1];
    t_cell w_cell  [CELLS+1];
    logic  w_ready [CELLS+1];

    pbm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_valid (i_pix.valid),
        .i_a     (i_pix.top_value),
        .i_b     (i_pix.bottom_value),
        .o_ready (i_pix.ready),
        .o_valid (w_front_valid),
        .o_work  (w_front_work),
        .i_ready (w_ready[0])
    );

    assign w_valid[0]  = w_front_valid;
    assign w_cell[0].w = w_front_work;
    assign w_cell[0].r = '0;
    assign w_cell[0].ok0 = 1'b0;

    // first cell checks code zero, the rest settle bits msb first
    generate
        for (genvar g = 0; g < CELLS; g++) begin : g_cell
            pbm_round_cell #(
                .BIT_IDX ((g == 0) ? -1 : CELLS - 1 - g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_valid[g]),
                .i_cell  (w_cell[g]),
                .o_ready (w_ready[g]),
                .o_valid (w_valid[g+1]),
                .o_cell  (w_cell[g+1]),
                .i_ready (w_ready[g+1])
            );
        end
    endgenerate

    // output register: clamp and clip decision
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_value, n_out_value;
    logic             r_out_clip, n_out_clip;
    t_cell            w_last;

    assign w_last           = w_cell[CELLS];
    assign w_ready[CELLS]   = !r_out_valid || o_px.ready;

    always_comb begin
        if (w_last.w.forced) begin
            // zero divisor saturates
            n_out_value = w_last.w.fval;
            n_out_clip  = w_last.w.fclip;
        end else if (!w_last.ok0) begin
            // value below -1/2
            n_out_value = '0;
            n_out_clip  = 1'b1;
        end else if (w_last.r[N_W-1]) begin
            // value at or above 255.5
            n_out_value = '1;
            n_out_clip  = 1'b1;
        end else begin
            n_out_value = w_last.r[PIX_W-1:0];
            n_out_clip  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ready[CELLS]) begin
            r_out_valid <= w_valid[CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[CELLS]) begin
            r_out_value <= n_out_value;
            r_out_clip  <= n_out_clip;
        end
    end

    assign o_px.valid         = r_out_valid;
    assign o_px.blended_value = r_out_value;
    assign o_px.clipped       = r_out_clip;

endmodule
`default_nettype wire

/* rtl/pbm_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pbm_checker
// port-level checks of the pixel blend mode unit
// ----------------------------------------------------------------------------
module pbm_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_value,
    input wire logic       i_out_clip
);

    // an empty output register means the whole pipeline can take input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input not ready while output empty");

    // clipping only ever lands on the rails
    a_clip_rails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_clip) |-> (i_out_value == 8'd0 || i_out_value == 8'd255))
        else $error("clip flag on an in-range value");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_value) && $stable(i_out_clip)))
        else $error("stalled result changed");

endmodule

bind pixel_blend_mode_unit pbm_checker u_pbm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_px.valid),
    .i_out_ready (o_px.ready),
    .i_out_value (o_px.blended_value),
    .i_out_clip  (o_px.clipped)
);
`default_nettype wire

/* sim/pixel_blend_mode_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_blend_mode_unit_test
// self-checking bench: every blend mode is set in turn, directed corner
// operands and random operands are streamed through with random gaps and
// back-pressure, and each result is compared against an exact integer
// rounding model of the blend formula
// ----------------------------------------------------------------------------
module pixel_blend_mode_unit_test;
    import pbm_pkg::*;

    typedef struct packed {
        logic [7:0] top;
        logic [7:0] bottom;
    } t_operands;

    typedef struct packed {
        logic [7:0] value;
        logic       clip;
    } t_blend;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [3:0] i_cfg_data;

    pbm_in_if  pix_if ();
    pbm_out_if px_if ();

    pixel_blend_mode_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_if.sink),
        .o_px       (px_if.source)
    );

    t_operands pending_pixels[$];   // operands not yet offered
    t_blend    expected_blends[$];  // predicted results in flight
    t_mode     model_mode;          // bench copy of the blend mode register
    int        n_errors;
    int        n_checked;
    int        n_clipped;
    bit        in_taken;
    bit        out_taken;
    int        send_gap;
    int        recv_stall;
    bit        no_idle;             // burst phase: neither side idles

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // true when code n minus one half does not exceed (p + k*sqrt(m)) / d
    function automatic bit code_fits(longint n, longint p, longint k, longint m, longint d);
        longint lhs;
        longint kk;
        lhs = 2 * n * d - d - 2 * p;
        kk  = 2 * k;
        if (kk == 0) return lhs <= 0;
        if (kk > 0) begin
            if (lhs <= 0) return 1'b1;
            return lhs * lhs <= kk * kk * m;
        end
        if (lhs >= 0) return 1'b0;
        return lhs * lhs >= kk * kk * m;
    endfunction

    // round to nearest, ties up, and saturate to a channel code
    function automatic t_blend round_clamp(longint p, longint k, longint m, longint d);
        t_blend res;
        longint n;
        n = 0;
        while (n <= 256 && code_fits(n, p, k, m, d)) n++;
        res.clip = 1'b0;
        if (n == 0) begin
            res.value = 8'd0;
            res.clip  = 1'b1;
        end else if (n - 1 > 255) begin
            res.value = 8'd255;
            res.clip  = 1'b1;
        end else begin
            res.value = 8'(n - 1);
        end
        return res;
    endfunction

    function automatic t_blend blend_predict(t_mode mode, t_operands op);
        t_blend res;
        longint a;
        longint b;
        longint ia;
        longint ib;
        longint k;
        longint cube;
        a  = op.top;
        b  = op.bottom;
        ia = 255 - a;
        ib = 255 - b;
        k  = 2 * b - 255;
        res = '0;
        case (mode)
            MODE_MULTIPLY: res = round_clamp(a * b, 0, 0, 255);
            MODE_SCREEN:   res = round_clamp(65025 - ia * ib, 0, 0, 255);
            MODE_OVERLAY: begin
                if (a <= 127) res = round_clamp(2 * a * b, 0, 0, 255);
                else          res = round_clamp(65025 - 2 * ia * ib, 0, 0, 255);
            end
            MODE_HARD: begin
                if (b <= 127) res = round_clamp(2 * a * b, 0, 0, 255);
                else          res = round_clamp(65025 - 2 * ia * ib, 0, 0, 255);
            end
            MODE_SOFT_PS: begin
                if (b <= 127)
                    res = round_clamp(2 * a * b * 255 + a * a * (255 - 2 * b), 0, 0, 65025);
                else
                    res = round_clamp(2 * a * ib, k, 255 * a, 255);
            end
            MODE_PEGTOP:
                res = round_clamp((255 - 2 * b) * a * a + 2 * b * a * 255, 0, 0, 65025);
            MODE_W3C: begin
                if (b <= 127) begin
                    res = round_clamp(65025 * a - (255 - 2 * b) * a * ia, 0, 0, 65025);
                end else if (a <= 63) begin
                    // cubic branch of the lightening curve, below a quarter
                    cube = 16 * a * a * a - 3060 * a * a + 260100 * a;
                    res  = round_clamp(a * 16581375 + k * (cube - 65025 * a), 0, 0, 16581375);
                end else begin
                    res = round_clamp(255 * a - k * a, k, 255 * a, 255);
                end
            end
            MODE_CDODGE: begin
                if (ia == 0) res = '{value: 8'd255, clip: 1'b1};
                else         res = round_clamp(255 * b, 0, 0, ia);
            end
            MODE_ADD: res = round_clamp(a + b, 0, 0, 1);
            MODE_CBURN: begin
                if (a == 0) res = '{value: 8'd0, clip: 1'b1};
                else        res = round_clamp(255 * (a + b - 255), 0, 0, a);
            end
            MODE_SUB: res = round_clamp(a + b - 255, 0, 0, 1);
            MODE_DIVIDE: begin
                if (b == 0) res = '{value: 8'd255, clip: 1'b1};
                else        res = round_clamp(255 * a, 0, 0, b);
            end
            MODE_DIFF:    res.value = 8'(a > b ? a - b : b - a);
            MODE_DARKEN:  res.value = 8'(a < b ? a : b);
            MODE_LIGHTEN: res.value = 8'(a < b ? b : a);
            default:      res = round_clamp(a + b, 0, 0, 2);
        endcase
        return res;
    endfunction

    // predict on every accepted input transaction
    always @(posedge i_clk) begin
        if (i_rst_n && pix_if.valid && pix_if.ready)
            expected_blends.push_back(blend_predict(model_mode,
                                      '{top: pix_if.top_value, bottom: pix_if.bottom_value}));
        in_taken <= i_rst_n && pix_if.valid && pix_if.ready;
    end

    // driver: offers queued operands, random gap after each transaction
    always @(negedge i_clk) begin
        if (pix_if.valid && in_taken) begin
            pix_if.valid = 1'b0;
            send_gap     = no_idle ? 0 : $urandom_range(0, 9);
        end
        if (!pix_if.valid && i_rst_n) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_pixels.size() > 0) begin
                pix_if.top_value    = pending_pixels[0].top;
                pix_if.bottom_value = pending_pixels[0].bottom;
                pix_if.valid        = 1'b1;
                void'(pending_pixels.pop_front());
            end
        end
    end

    // monitor: compares each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_blend want;
        if (i_rst_n && px_if.valid && px_if.ready) begin
            if (expected_blends.size() == 0) begin
                $error("unexpected result transaction: blended_value %0d clipped %0d",
                       px_if.blended_value, px_if.clipped);
                n_errors++;
            end else begin
                want = expected_blends.pop_front();
                n_checked++;
                if (want.clip) n_clipped++;
                if (px_if.blended_value !== want.value) begin
                    $error("blended_value: expected %0d, actual %0d (mode %s)",
                           want.value, px_if.blended_value, model_mode.name());
                    n_errors++;
                end
                if (px_if.clipped !== want.clip) begin
                    $error("clipped: expected %0d, actual %0d (mode %s)",
                           want.clip, px_if.clipped, model_mode.name());
                    n_errors++;
                end
            end
        end
        out_taken <= i_rst_n && px_if.valid && px_if.ready;
    end

    // receiver back-pressure: random stall after each taken result
    always @(negedge i_clk) begin
        if (px_if.ready && out_taken) begin
            recv_stall = no_idle ? 0 : $urandom_range(0, 9);
            if (recv_stall > 0) px_if.ready = 1'b0;
        end else if (!px_if.ready && i_rst_n) begin
            if (recv_stall > 0) recv_stall--;
            if (recv_stall == 0) px_if.ready = 1'b1;
        end
    end

    // waits for the pipeline to drain, then for its full latency
    task automatic drain_pipeline();
        while (pending_pixels.size() > 0 || pix_if.valid || expected_blends.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_mode(t_mode mode);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = mode;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        model_mode = mode;
    endtask

    initial begin
        t_operands corner[$];
        t_operands op;
        int        idx;

        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_data          = '0;
        pix_if.valid        = 1'b0;
        pix_if.top_value    = '0;
        pix_if.bottom_value = '0;
        px_if.ready         = 1'b0;
        model_mode          = MODE_MULTIPLY;
        n_errors            = 0;
        n_checked           = 0;
        n_clipped           = 0;
        send_gap            = 0;
        recv_stall          = 0;
        no_idle             = 1'b0;

        // operand corners: full range, zero divisors, half-point and quarter splits
        corner = '{'{8'd0, 8'd0}, '{8'd255, 8'd255}, '{8'd0, 8'd255}, '{8'd255, 8'd0},
                   '{8'd127, 8'd128}, '{8'd128, 8'd127}, '{8'd63, 8'd200},
                   '{8'd64, 8'd200}, '{8'd170, 8'd85}};

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n     = 1'b1;
        px_if.ready = 1'b1;

        // reset mode is multiply: run corners before any register write
        foreach (corner[j]) pending_pixels.push_back(corner[j]);
        drain_pipeline();

        // every mode in turn, then the two extremes again at full rate
        for (idx = 0; idx < 18; idx++) begin
            write_mode(t_mode'(idx < 16 ? idx : (idx == 16 ? 0 : 15)));
            no_idle = (idx >= 16) || ($urandom_range(0, 3) == 0);
            if (idx < 16 && idx != 0)
                foreach (corner[j]) pending_pixels.push_back(corner[j]);
            repeat (idx < 16 ? 55 : 40) begin
                op.top    = $urandom_range(0, 255);
                op.bottom = $urandom_range(0, 255);
                pending_pixels.push_back(op);
            end
            drain_pipeline();
        end

        $display("covered all 16 blend modes with corner and random operands under stalls");
        $display("%0d results checked, %0d of them clipped", n_checked, n_clipped);
        if (n_errors == 0)
            $display("pixel_blend_mode_unit: match");
        else
            $display("pixel_blend_mode_unit: mismatch");
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("pixel_blend_mode_unit: mismatch");
        $finish;
    end

endmodule
